// ===== hw/rtl/pfpu_pkg.sv =====
package pfpu_pkg;

  // Stored pixel formats; codes above BGRA32 are not supported
  typedef enum logic [3:0] {
    FMT_GRAY8    = 4'd0,
    FMT_GRAY16   = 4'd1,
    FMT_RGB555   = 4'd2,
    FMT_RGB565   = 4'd3,
    FMT_ARGB1555 = 4'd4,
    FMT_RGB24    = 4'd5,
    FMT_BGR24    = 4'd6,
    FMT_ARGB32   = 4'd7,
    FMT_ABGR32   = 4'd8,
    FMT_RGBA32   = 4'd9,
    FMT_BGRA32   = 4'd10
  } pix_fmt_e;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_NOT_IMPL = 1'b1
  } status_e;

  localparam logic [3:0] FmtReset = FMT_ARGB32;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } argb_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] raw;
    argb_t       argb;
  } item_t;

  typedef struct packed {
    logic [31:0] packed_px;
    argb_t       argb;
    status_e     status;
  } result_t;

endpackage

// ===== hw/rtl/pfpu_unpack.sv =====
module pfpu_unpack (
  input  logic [3:0]      fmt_i,
  input  logic [31:0]     raw_i,
  output pfpu_pkg::argb_t argb_o
);

  // Widen a 5-bit channel: c*255/31 = 8c + floor(7c/31)
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0] p;
    logic [2:0] f;
    p = 8'({3'b000, c} * 8'd7);
    priority if (p >= 8'd217) f = 3'd7;
    else if (p >= 8'd186) f = 3'd6;
    else if (p >= 8'd155) f = 3'd5;
    else if (p >= 8'd124) f = 3'd4;
    else if (p >= 8'd93)  f = 3'd3;
    else if (p >= 8'd62)  f = 3'd2;
    else if (p >= 8'd31)  f = 3'd1;
    else                  f = 3'd0;
    return {c, 3'b000} + {5'b00000, f};
  endfunction

  // Widen a 6-bit channel: c*255/63 = 4c + floor(c/21)
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [1:0] f;
    priority if (c >= 6'd63) f = 2'd3;
    else if (c >= 6'd42) f = 2'd2;
    else if (c >= 6'd21) f = 2'd1;
    else                 f = 2'd0;
    return {c, 2'b00} + {6'b000000, f};
  endfunction

  // Gray16 to gray8: h/257 from the high byte, one lower when the low byte is short
  function automatic logic [7:0] div257(input logic [15:0] h);
    logic [7:0] t;
    t = h[15:8];
    return (h[7:0] >= t) ? t : t - 8'd1;
  endfunction

  logic [15:0] half;

  assign half = raw_i[15:0];

  // Pick the channels apart for the stored format
  always_comb begin
    argb_o = '0;
    unique case (fmt_i)
      pfpu_pkg::FMT_GRAY8: begin
        argb_o = {8'hFF, raw_i[7:0], raw_i[7:0], raw_i[7:0]};
      end
      pfpu_pkg::FMT_GRAY16: begin
        argb_o = {8'hFF, div257(half), div257(half), div257(half)};
      end
      pfpu_pkg::FMT_RGB555: begin
        argb_o = {8'hFF, widen5(half[14:10]), widen5(half[9:5]), widen5(half[4:0])};
      end
      pfpu_pkg::FMT_RGB565: begin
        argb_o = {8'hFF, widen5(half[15:11]), widen6(half[10:5]), widen5(half[4:0])};
      end
      pfpu_pkg::FMT_ARGB1555: begin
        argb_o = {{8{half[15]}}, widen5(half[14:10]), widen5(half[9:5]),
                  widen5(half[4:0])};
      end
      pfpu_pkg::FMT_RGB24: begin
        argb_o = {8'hFF, raw_i[7:0], raw_i[15:8], raw_i[23:16]};
      end
      pfpu_pkg::FMT_BGR24: begin
        argb_o = {8'hFF, raw_i[23:16], raw_i[15:8], raw_i[7:0]};
      end
      pfpu_pkg::FMT_ARGB32: begin
        argb_o = {raw_i[7:0], raw_i[15:8], raw_i[23:16], raw_i[31:24]};
      end
      pfpu_pkg::FMT_ABGR32: begin
        argb_o = {raw_i[7:0], raw_i[31:24], raw_i[23:16], raw_i[15:8]};
      end
      pfpu_pkg::FMT_RGBA32: begin
        argb_o = {raw_i[31:24], raw_i[7:0], raw_i[15:8], raw_i[23:16]};
      end
      pfpu_pkg::FMT_BGRA32: begin
        argb_o = {raw_i[31:24], raw_i[23:16], raw_i[15:8], raw_i[7:0]};
      end
      default: begin
        argb_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pfpu_pack.sv =====
module pfpu_pack (
  input  logic [3:0]      fmt_i,
  input  pfpu_pkg::argb_t argb_i,
  output logic [31:0]     packed_o
);

  // Narrow to 5 bits: floor(31c/255) via x/255 = (x + (x>>8) + 1) >> 8
  function automatic logic [4:0] narrow5(input logic [7:0] c);
    logic [12:0] x;
    logic [12:0] s;
    x = 13'({5'b00000, c} * 13'd31);
    s = x + {8'b0, x[12:8]} + 13'd1;
    return s[12:8];
  endfunction

  // Narrow to 6 bits: floor(63c/255)
  function automatic logic [5:0] narrow6(input logic [7:0] c);
    logic [13:0] x;
    logic [13:0] s;
    x = 14'({6'b000000, c} * 14'd63);
    s = x + {8'b0, x[13:8]} + 14'd1;
    return s[13:8];
  endfunction

  logic [23:0] luma_sum;
  logic [7:0]  luma;
  logic [4:0]  r5, g5, b5;
  logic [5:0]  g6;

  // Q16 luma; the weights sum to 65536 so the total fits in 24 bits
  assign luma_sum = 24'(argb_i.r) * 24'd19595 + 24'(argb_i.g) * 24'd38470
                  + 24'(argb_i.b) * 24'd7471;
  assign luma     = luma_sum[23:16];

  assign r5 = narrow5(argb_i.r);
  assign g5 = narrow5(argb_i.g);
  assign b5 = narrow5(argb_i.b);
  assign g6 = narrow6(argb_i.g);

  // Assemble the stored word, byte 0 lowest
  always_comb begin
    packed_o = '0;
    unique case (fmt_i)
      pfpu_pkg::FMT_GRAY8:    packed_o = {24'b0, luma};
      pfpu_pkg::FMT_GRAY16:   packed_o = {16'b0, luma, luma};
      pfpu_pkg::FMT_RGB555:   packed_o = {17'b0, r5, g5, b5};
      pfpu_pkg::FMT_RGB565:   packed_o = {16'b0, r5, g6, b5};
      pfpu_pkg::FMT_ARGB1555: packed_o = {16'b0, (argb_i.a != 8'd0), r5, g5, b5};
      pfpu_pkg::FMT_RGB24:    packed_o = {8'b0, argb_i.b, argb_i.g, argb_i.r};
      pfpu_pkg::FMT_BGR24:    packed_o = {8'b0, argb_i.r, argb_i.g, argb_i.b};
      pfpu_pkg::FMT_ARGB32:   packed_o = {argb_i.b, argb_i.g, argb_i.r, argb_i.a};
      pfpu_pkg::FMT_ABGR32:   packed_o = {argb_i.r, argb_i.g, argb_i.b, argb_i.a};
      pfpu_pkg::FMT_RGBA32:   packed_o = {argb_i.a, argb_i.b, argb_i.g, argb_i.r};
      pfpu_pkg::FMT_BGRA32:   packed_o = {argb_i.a, argb_i.r, argb_i.g, argb_i.b};
      default:                packed_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/pixel_format_pack_unpack_core.sv =====
// Channel   Handshake                Payload
// ------    ---------                -------
// in        in_valid_i / in_ready_o  command_i, raw_pixel_i, alpha/red/green/blue_in_i
// out       out_valid_o/ out_ready_i packed_pixel_o, alpha/red/green/blue_out_o, status_o
// cfg       cfg_we_i                 cfg_wdata_i (pixel format code)
//
// One item per cycle sustained unless the output stalls; each item passes through
// an input register, then the conversion logic into the result register.
// Reset clears both valid flags and sets the format to ARGB32.
// A stalled result holds the result register; the input register still takes an
// item while it is empty, so in_ready_o drops only when both registers are full.
module pixel_format_pack_unpack_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] raw_pixel_i,
  input  logic [7:0]  alpha_in_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] packed_pixel_o,
  output logic [7:0]  alpha_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        status_o
);

  logic [3:0]        fmt_q;
  logic              in_valid_q;
  pfpu_pkg::item_t   item_q;
  logic              out_valid_q;
  pfpu_pkg::result_t res_q;
  pfpu_pkg::result_t res_d;
  logic              advance;
  logic              supported;
  pfpu_pkg::argb_t   unpacked;
  logic [31:0]       packed_word;

  // Format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pfpu_pkg::FmtReset;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // Move the held item on when the result register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd  <= pfpu_pkg::cmd_e'(command_i);
      item_q.raw  <= raw_pixel_i;
      item_q.argb <= {alpha_in_i, red_in_i, green_in_i, blue_in_i};
    end
  end

  pfpu_unpack u_unpack (
    .fmt_i  (fmt_q),
    .raw_i  (item_q.raw),
    .argb_o (unpacked)
  );

  pfpu_pack u_pack (
    .fmt_i    (fmt_q),
    .argb_i   (item_q.argb),
    .packed_o (packed_word)
  );

  assign supported = (fmt_q <= pfpu_pkg::FMT_BGRA32);

  // Select the result; unused fields are zero, an unsupported format gives only its status
  always_comb begin
    res_d = '0;
    if (!supported) begin
      res_d.status = pfpu_pkg::ST_NOT_IMPL;
    end else if (item_q.cmd == pfpu_pkg::CMD_WRITE) begin
      res_d.packed_px = packed_word;
    end else begin
      res_d.argb = unpacked;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_pixel_o = res_q.packed_px;
  assign alpha_out_o    = res_q.argb.a;
  assign red_out_o      = res_q.argb.r;
  assign green_out_o    = res_q.argb.g;
  assign blue_out_o     = res_q.argb.b;
  assign status_o       = res_q.status;

  // Both registers full and the output stalled: refuse new items
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are full");

  // A held item that moves on shows up as a valid result
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("item lost between stages");

  // An unsupported format result carries nothing but its status
  a_not_impl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == pfpu_pkg::ST_NOT_IMPL
      |-> res_q.packed_px == 32'd0 && res_q.argb == '0)
    else $error("unsupported format result has nonzero fields");

  // A result that waits is not replaced
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule

// ===== test/tb_pixel_format_pack_unpack_core.sv =====
module tb_pixel_format_pack_unpack_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles = 8;
  localparam int ItemsPerFormat = 106;
  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles = 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = 4'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = pfpu_pkg::CMD_READ;
  logic [31:0] raw_pixel_i = 32'd0;
  logic [7:0]  alpha_in_i = 8'd0;
  logic [7:0]  red_in_i = 8'd0;
  logic [7:0]  green_in_i = 8'd0;
  logic [7:0]  blue_in_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] packed_pixel_o;
  logic [7:0]  alpha_out_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        status_o;

  pixel_format_pack_unpack_core uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .raw_pixel_i,
    .alpha_in_i,
    .red_in_i,
    .green_in_i,
    .blue_in_i,
    .out_valid_o,
    .out_ready_i,
    .packed_pixel_o,
    .alpha_out_o,
    .red_out_o,
    .green_out_o,
    .blue_out_o,
    .status_o
  );

  // Pixels waiting to be driven, and conversions waiting to come out
  pfpu_pkg::item_t   pixels_to_send[$];
  pfpu_pkg::result_t pixels_due[$];
  logic [3:0]        fmt_model = pfpu_pkg::FmtReset;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        in_acc = 1'b0;
  logic        out_acc = 1'b0;

  // Sender and receiver pacing: runs of random waits or of none at all
  int          tx_gap = 0;
  int          tx_run = 0;
  bit          tx_calm = 1'b0;
  int          rx_wait = 0;
  int          rx_run = 0;
  bit          rx_calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Channel scaling, all truncating
  function automatic logic [7:0] expand5(logic [4:0] c);
    int unsigned v;
    v = c;
    return 8'(v * 255 / 31);
  endfunction

  function automatic logic [7:0] expand6(logic [5:0] c);
    int unsigned v;
    v = c;
    return 8'(v * 255 / 63);
  endfunction

  function automatic logic [4:0] shrink5(logic [7:0] c);
    int unsigned v;
    v = c;
    return 5'(v * 31 / 255);
  endfunction

  function automatic logic [5:0] shrink6(logic [7:0] c);
    int unsigned v;
    v = c;
    return 6'(v * 63 / 255);
  endfunction

  // Q16 luma with weights 0.299, 0.587, 0.114
  function automatic logic [7:0] gray_of(pfpu_pkg::argb_t px);
    int unsigned sum;
    sum = 19595 * int'(px.r) + 38470 * int'(px.g) + 7471 * int'(px.b);
    return 8'(sum >> 16);
  endfunction

  // Expected conversion of one pixel under the given stored format
  function automatic pfpu_pkg::result_t convert_pixel(logic [3:0] fmt,
                                                      pfpu_pkg::item_t it);
    pfpu_pkg::result_t res;
    logic [15:0]       h;
    logic [31:0]       w;
    pfpu_pkg::argb_t   c;
    logic [7:0]        y;
    res = '0;
    h = it.raw[15:0];
    w = it.raw;
    c = it.argb;
    res.status = pfpu_pkg::ST_OK;
    if (fmt > pfpu_pkg::FMT_BGRA32) begin
      res.status = pfpu_pkg::ST_NOT_IMPL;
    end else if (it.cmd == pfpu_pkg::CMD_WRITE) begin
      y = gray_of(c);
      case (fmt)
        pfpu_pkg::FMT_GRAY8:    res.packed_px = {24'd0, y};
        pfpu_pkg::FMT_GRAY16:   res.packed_px = {16'd0, 16'(y * 257)};
        pfpu_pkg::FMT_RGB555:
          res.packed_px = {17'd0, shrink5(c.r), shrink5(c.g), shrink5(c.b)};
        pfpu_pkg::FMT_RGB565:
          res.packed_px = {16'd0, shrink5(c.r), shrink6(c.g), shrink5(c.b)};
        pfpu_pkg::FMT_ARGB1555:
          res.packed_px = {16'd0, c.a != 8'd0, shrink5(c.r), shrink5(c.g),
                           shrink5(c.b)};
        pfpu_pkg::FMT_RGB24:    res.packed_px = {8'd0, c.b, c.g, c.r};
        pfpu_pkg::FMT_BGR24:    res.packed_px = {8'd0, c.r, c.g, c.b};
        pfpu_pkg::FMT_ARGB32:   res.packed_px = {c.b, c.g, c.r, c.a};
        pfpu_pkg::FMT_ABGR32:   res.packed_px = {c.r, c.g, c.b, c.a};
        pfpu_pkg::FMT_RGBA32:   res.packed_px = {c.a, c.b, c.g, c.r};
        default:                res.packed_px = {c.a, c.r, c.g, c.b};
      endcase
    end else begin
      res.argb.a = 8'd255;
      case (fmt)
        pfpu_pkg::FMT_GRAY8: begin
          res.argb.r = w[7:0];
          res.argb.g = w[7:0];
          res.argb.b = w[7:0];
        end
        pfpu_pkg::FMT_GRAY16: begin
          res.argb.r = 8'(h / 257);
          res.argb.g = 8'(h / 257);
          res.argb.b = 8'(h / 257);
        end
        pfpu_pkg::FMT_RGB555, pfpu_pkg::FMT_ARGB1555: begin
          if (fmt == pfpu_pkg::FMT_ARGB1555) res.argb.a = h[15] ? 8'd255 : 8'd0;
          res.argb.r = expand5(h[14:10]);
          res.argb.g = expand5(h[9:5]);
          res.argb.b = expand5(h[4:0]);
        end
        pfpu_pkg::FMT_RGB565: begin
          res.argb.r = expand5(h[15:11]);
          res.argb.g = expand6(h[10:5]);
          res.argb.b = expand5(h[4:0]);
        end
        pfpu_pkg::FMT_RGB24:  res.argb = {8'd255, w[7:0], w[15:8], w[23:16]};
        pfpu_pkg::FMT_BGR24:  res.argb = {8'd255, w[23:16], w[15:8], w[7:0]};
        pfpu_pkg::FMT_ARGB32: res.argb = {w[7:0], w[15:8], w[23:16], w[31:24]};
        pfpu_pkg::FMT_ABGR32: res.argb = {w[7:0], w[31:24], w[23:16], w[15:8]};
        pfpu_pkg::FMT_RGBA32: res.argb = {w[31:24], w[7:0], w[15:8], w[23:16]};
        default:              res.argb = {w[31:24], w[23:16], w[15:8], w[7:0]};
      endcase
    end
    return res;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Drive the next pixel at the falling edge; hold it until it is taken
  always @(negedge clk_i) begin
    pfpu_pkg::item_t nxt;
    logic            drive_valid;
    if (rst_ni) begin
      drive_valid = in_valid_i && !in_acc;
      if (!drive_valid) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pixels_to_send.size() != 0) begin
          nxt = pixels_to_send.pop_front();
          command_i   <= nxt.cmd;
          raw_pixel_i <= nxt.raw;
          alpha_in_i  <= nxt.argb.a;
          red_in_i    <= nxt.argb.r;
          green_in_i  <= nxt.argb.g;
          blue_in_i   <= nxt.argb.b;
          drive_valid = 1'b1;
          if (tx_run == 0) begin
            tx_run = $urandom_range(8, 64);
            tx_calm = ($urandom_range(0, 3) == 0);
          end
          tx_run--;
          tx_gap = tx_calm ? 0 : $urandom_range(0, 11);
        end
      end
      in_valid_i <= drive_valid;
    end
  end

  // Stall the result side for a drawn number of cycles per item
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_acc) begin
        if (rx_run == 0) begin
          rx_run = $urandom_range(8, 64);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        rx_run--;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
      end
      if (rx_wait != 0) begin
        if (out_valid_o) rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check results against the oldest expectation, then record new pixels
  always @(posedge clk_i) begin
    pfpu_pkg::item_t   it;
    pfpu_pkg::result_t want;
    if (rst_ni) begin
      in_acc  <= in_valid_i && in_ready_o;
      out_acc <= out_valid_o && out_ready_i;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pixels_due.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, got packed %h",
                   $time, packed_pixel_o);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          compare_field("packed_pixel", want.packed_px, packed_pixel_o);
          compare_field("alpha_out", want.argb.a, alpha_out_o);
          compare_field("red_out", want.argb.r, red_out_o);
          compare_field("green_out", want.argb.g, green_out_o);
          compare_field("blue_out", want.argb.b, blue_out_o);
          compare_field("status", want.status, status_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        it.cmd    = pfpu_pkg::cmd_e'(command_i);
        it.raw    = raw_pixel_i;
        it.argb.a = alpha_in_i;
        it.argb.r = red_in_i;
        it.argb.g = green_in_i;
        it.argb.b = blue_in_i;
        pixels_due.push_back(convert_pixel(fmt_model, it));
        items_taken++;
      end
      // Watchdog: give up when nothing moves for too long
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_pixel(input pfpu_pkg::cmd_e cmd, input logic [31:0] raw,
                             input logic [7:0] a, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    pfpu_pkg::item_t it;
    it.cmd  = cmd;
    it.raw  = raw;
    it.argb = {a, r, g, b};
    pixels_to_send.push_back(it);
    items_queued++;
  endtask

  // Hold off until every pixel has been answered and the pipeline has settled
  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_format(input logic [3:0] code);
    wait_drained();
    cfg_wdata_i <= code;
    cfg_we_i    <= 1'b1;
    fmt_model = code;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly random channel values, with the extremes weighted in
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0]  order[16];
    logic [3:0]  swap;
    logic [31:0] raw;
    int          j;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset format, no write yet
    queue_pixel(pfpu_pkg::CMD_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(pfpu_pkg::CMD_READ, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);

    // One-bit alpha: set by any nonzero alpha, read back from bit 15
    program_format(pfpu_pkg::FMT_ARGB1555);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h0, 8'h00, 8'hFF, 8'h80, 8'h01);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h0, 8'h01, 8'h08, 8'hFF, 8'h00);
    queue_pixel(pfpu_pkg::CMD_READ, 32'h0000_8000, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(pfpu_pkg::CMD_READ, 32'hFFFF_7FFF, 8'h00, 8'h00, 8'h00, 8'h00);

    // 16-bit word with the upper half set, which must be ignored
    program_format(pfpu_pkg::FMT_RGB565);
    queue_pixel(pfpu_pkg::CMD_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00);

    // Gray16: full-scale luma and a word just under 257
    program_format(pfpu_pkg::FMT_GRAY16);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(pfpu_pkg::CMD_READ, 32'h0000_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(pfpu_pkg::CMD_READ, 32'hFFFF_0100, 8'h00, 8'h00, 8'h00, 8'h00);

    program_format(pfpu_pkg::FMT_GRAY8);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(pfpu_pkg::CMD_READ, 32'hFFFF_FF80, 8'h00, 8'h00, 8'h00, 8'h00);

    // Unsupported codes answer with status only
    program_format(4'd15);
    queue_pixel(pfpu_pkg::CMD_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    program_format(4'd11);
    queue_pixel(pfpu_pkg::CMD_WRITE, 32'h1234_5678, 8'h12, 8'h34, 8'h56, 8'h78);

    // Visit every format code in a shuffled order
    for (int i = 0; i < 16; i++) order[i] = 4'(i);
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = order[i];
      order[i] = order[j];
      order[j] = swap;
    end

    for (int p = 0; p < 16; p++) begin
      program_format(order[p]);
      for (int n = 0; n < ItemsPerFormat; n++) begin
        case ($urandom_range(0, 7))
          0:       raw = 32'h0000_0000;
          1:       raw = 32'hFFFF_FFFF;
          default: raw = $urandom;
        endcase
        queue_pixel(pfpu_pkg::cmd_e'($urandom_range(0, 1)), raw, pick_channel(),
                    pick_channel(), pick_channel(), pick_channel());
      end
    end

    wait_drained();
    if (pixels_due.size() != 0) begin
      $display("%0t: %0d conversions never came out, expected none left, got %0d",
               $time, pixels_due.size(), pixels_due.size());
      mismatches++;
    end

    $display("Converted %0d pixels, reads and writes, over all 16 format codes", items_taken);
    $display("with random stalls on both sides: %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
